FILE: sv/rash_pkg.sv
// Shared widths, register indexes and error-hash helper for the reduced-alphabet seed hash.
package rash_pkg;

   localparam int HASH_W       = 64;
   localparam int CODE_W       = 4;
   localparam int SYM_W        = 5;
   localparam int LEN_W        = 5;
   localparam int SCORE_W      = 16;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 64;
   localparam int MIN_LENGTH   = 4;
   localparam int LENGTH_BOUND = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOP_CODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HIGH   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_HIGH = 3'd6;

   localparam logic [CODE_W-1:0]  TOP_CODE_RESET   = 4'd15;
   localparam logic [LEN_W-1:0]   MAX_LENGTH_RESET = 5'd12;
   localparam logic [HASH_W-1:0]  ERR_HASH_RESET   = 64'h0001_0000_0000_0000;

   // shift width: smallest s with 2^s >= largest valid code
   function automatic logic [2:0] shift_of(input logic [CODE_W-1:0] mc);
      logic [2:0] s;
      if (mc <= 4'd1) begin
         s = 3'd0;
      end else if (mc == 4'd2) begin
         s = 3'd1;
      end else if (mc <= 4'd4) begin
         s = 3'd2;
      end else if (mc <= 4'd8) begin
         s = 3'd3;
      end else begin
         s = 3'd4;
      end
      return s;
   endfunction

   // largest valid code OR-ed in at len shifts of s bits; fields overlap where the code equals 2^s
   function automatic logic [HASH_W-1:0] max_hash_of(input logic [CODE_W-1:0] mc,
                                                     input logic [2:0]        s,
                                                     input logic [LEN_W-1:0]  len);
      logic [HASH_W-1:0] h;
      h = '0;
      if (s == 3'd0) begin
         h = (mc == '0) ? '0 : {{(HASH_W-LEN_W){1'b0}}, len};
      end else begin
         for (int i = 0; i < LENGTH_BOUND; i++) begin
            if (i < int'(len)) begin
               h = h | ({{(HASH_W-CODE_W){1'b0}}, mc} << (int'(s) * i));
            end
         end
      end
      return h;
   endfunction

endpackage

FILE: sv/reduced_alphabet_seed_hash_unit.sv
// Reduced-alphabet seed hash: input stage, single-pass step logic and result register.
// A result passes from the input stage through the step logic into the result register.
// Throughput: one symbol per cycle unless stalled; the step logic is two table lookups,
//   a shift of up to four bits and a 64-bit add between input stage and result register.
// The error hash is re-derived from configuration each cycle and registered.
// Reset (synchronous, active high) drops the seed and clears both stages;
//   configuration returns to its reset values.
module reduced_alphabet_seed_hash_unit
   import rash_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [SYM_W-1:0]       req_symbol,
   input  logic                   req_start_req,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [HASH_W-1:0]      rsp_seed_hash,
   output logic [LEN_W-1:0]       rsp_seed_length,
   output logic                   rsp_bad_symbol,
   input  logic                   csr_write_enable,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [CODE_W-1:0]         top_code_ff;
   logic signed [SCORE_W-1:0] threshold_ff;
   logic [LEN_W-1:0]          max_length_ff;
   logic [HASH_W-1:0]         map_low_ff, map_high_ff, score_low_ff, score_high_ff;
   logic [HASH_W-1:0]         err_hash_ff;

   logic                      stage_valid_ff, stage_valid_in;
   logic [SYM_W-1:0]          stage_symbol_ff;
   logic                      stage_start_ff;

   logic [HASH_W-1:0]         hash_ff, hash_in;
   logic signed [SCORE_W-1:0] score_ff, score_in;
   logic [LEN_W-1:0]          taken_ff, taken_in;
   logic                      active_ff, active_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]         rsp_hash_ff, rsp_hash_in;
   logic [LEN_W-1:0]          rsp_length_ff, rsp_length_in;
   logic                      rsp_bad_ff, rsp_bad_in;

   logic                      out_free, advance, req_accept, emit;
   logic [2:0]                shift_w;
   logic [LEN_W-1:0]          eff_len;

   assign shift_w    = shift_of(top_code_ff);
   assign eff_len    = (max_length_ff > LEN_W'(LENGTH_BOUND)) ? LEN_W'(LENGTH_BOUND)
                                                              : max_length_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign advance    = stage_valid_ff && out_free;
   assign req_stall  = stage_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      logic [HASH_W-1:0]         h_cur, h_shift;
      logic signed [SCORE_W-1:0] s_cur;
      logic [LEN_W-1:0]          t_cur, t_next;
      logic                      act;
      logic [HASH_W-1:0]         map_word, score_word;
      logic [CODE_W-1:0]         code;
      logic [7:0]                score_byte;

      act        = stage_start_ff || active_ff;
      h_cur      = stage_start_ff ? '0 : hash_ff;
      s_cur      = stage_start_ff ? '0 : score_ff;
      t_cur      = stage_start_ff ? '0 : taken_ff;
      map_word   = stage_symbol_ff[SYM_W-1] ? map_high_ff : map_low_ff;
      code       = map_word[{stage_symbol_ff[3:0], 2'b00} +: CODE_W];
      score_word = code[3] ? score_high_ff : score_low_ff;
      score_byte = score_word[{code[2:0], 3'b000} +: 8];
      t_next     = t_cur + LEN_W'(1);
      case (shift_w)
         3'd0:    h_shift = h_cur;
         3'd1:    h_shift = {h_cur[HASH_W-2:0], 1'b0};
         3'd2:    h_shift = {h_cur[HASH_W-3:0], 2'b0};
         3'd3:    h_shift = {h_cur[HASH_W-4:0], 3'b0};
         default: h_shift = {h_cur[HASH_W-5:0], 4'b0};
      endcase

      hash_in       = h_cur;
      score_in      = s_cur;
      taken_in      = t_cur;
      active_in     = act;
      emit          = 1'b0;
      rsp_hash_in   = h_cur;
      rsp_length_in = t_cur;
      rsp_bad_in    = 1'b0;

      if (!act) begin
         emit = 1'b0;
      end else if (t_cur >= eff_len) begin
         emit = 1'b1;
      end else if (code > top_code_ff) begin
         emit          = 1'b1;
         rsp_hash_in   = err_hash_ff;
         rsp_length_in = '0;
         rsp_bad_in    = 1'b1;
      end else if (t_cur >= LEN_W'(MIN_LENGTH) && s_cur >= threshold_ff) begin
         emit = 1'b1;
      end else begin
         hash_in       = h_shift + {{(HASH_W-CODE_W){1'b0}}, code};
         score_in      = s_cur + SCORE_W'(signed'(score_byte));
         taken_in      = t_next;
         rsp_hash_in   = hash_in;
         rsp_length_in = t_next;
         emit          = (t_next >= eff_len);
      end
      if (emit) begin
         active_in = 1'b0;
      end
   end

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (req_accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = advance && emit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_code_ff   <= TOP_CODE_RESET;
         threshold_ff  <= '0;
         max_length_ff <= MAX_LENGTH_RESET;
         map_low_ff    <= '0;
         map_high_ff   <= '0;
         score_low_ff  <= '0;
         score_high_ff <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TOP_CODE:   top_code_ff   <= csr_data[CODE_W-1:0];
            CSR_THRESHOLD:  threshold_ff  <= signed'(csr_data[SCORE_W-1:0]);
            CSR_MAX_LENGTH: max_length_ff <= csr_data[LEN_W-1:0];
            CSR_MAP_LOW:    map_low_ff    <= csr_data;
            CSR_MAP_HIGH:   map_high_ff   <= csr_data;
            CSR_SCORE_LOW:  score_low_ff  <= csr_data;
            CSR_SCORE_HIGH: score_high_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         err_hash_ff <= ERR_HASH_RESET;
      end else begin
         err_hash_ff <= max_hash_of(top_code_ff, shift_w, eff_len) + HASH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         active_ff      <= 1'b0;
         hash_ff        <= '0;
         score_ff       <= '0;
         taken_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance) begin
            active_ff <= active_in;
            hash_ff   <= hash_in;
            score_ff  <= score_in;
            taken_ff  <= taken_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         stage_symbol_ff <= req_symbol;
         stage_start_ff  <= req_start_req;
      end
      if (out_free && advance && emit) begin
         rsp_hash_ff   <= rsp_hash_in;
         rsp_length_ff <= rsp_length_in;
         rsp_bad_ff    <= rsp_bad_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_seed_hash   = rsp_hash_ff;
   assign rsp_seed_length = rsp_length_ff;
   assign rsp_bad_symbol  = rsp_bad_ff;

`ifndef SYNTHESIS
   a_bad_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_length_ff == '0)
      else $error("bad-symbol beat with non-zero length");

   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_length_ff <= LEN_W'(LENGTH_BOUND))
      else $error("seed length beyond bound");

   a_taken_bound: assert property (@(posedge clock) disable iff (reset)
      taken_ff <= LEN_W'(LENGTH_BOUND))
      else $error("symbol count overflow");

   a_emit_ends_seed: assert property (@(posedge clock) disable iff (reset)
      advance && emit |=> !active_ff && rsp_valid_ff)
      else $error("seed still active after result");

   a_stall_needs_stage: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> stage_valid_ff && rsp_valid_ff)
      else $error("input stalled with no work held");
`endif

endmodule
